### hdl/ipv4tli_pkg.sv
// Package for the IPv4 target list iterator: operation and status codes,
// field widths and the decoded-entry struct. No dependencies.
package ipv4tli_pkg;

   localparam int ADDR_W = 32;
   localparam int PLEN_W = 6;
   localparam int CNT_W  = 37;
   localparam int SIZE_W = 33;

   localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

   typedef enum logic [1:0] {
      OP_CLEAR  = 2'd0,
      OP_APPEND = 2'd1,
      OP_REWIND = 2'd2,
      OP_NEXT   = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_GIVEN    = 3'd0,
      ST_FINISHED = 3'd1,
      ST_ACCEPTED = 3'd2,
      ST_REJECTED = 3'd3,
      ST_FULL     = 3'd4,
      ST_DONE     = 3'd5
   } status_type;

   // Decoded append request.
   typedef struct packed {
      logic              ok;     // prefix in range / range not backwards
      logic [ADDR_W-1:0] first;
      logic [ADDR_W-1:0] last;
      logic [SIZE_W-1:0] size;   // last - first + 1
   } entry_type;

endpackage

### hdl/ipv4tli_decode.sv
// Entry decoder: turns a network/prefix or a range into an inclusive
// first/last pair with its size. Depends on ipv4tli_pkg.
module ipv4tli_decode (
   input  logic                          entry_kind,
   input  logic [ipv4tli_pkg::ADDR_W-1:0] first_addr,
   input  logic [ipv4tli_pkg::ADDR_W-1:0] range_end,
   input  logic [ipv4tli_pkg::PLEN_W-1:0] prefix_len,
   output ipv4tli_pkg::entry_type        entry
);
   import ipv4tli_pkg::*;

   logic [ADDR_W-1:0] host_mask;

   always_comb begin
      // shift by 32 yields zero: a /32 network is a single address
      host_mask = {ADDR_W{1'b1}} >> prefix_len;
      if (entry_kind == 1'b0) begin
         entry.ok    = (prefix_len <= PLEN_W'(ADDR_W));
         entry.first = first_addr & ~host_mask;
         entry.last  = first_addr | host_mask;
      end else begin
         entry.ok    = (range_end >= first_addr);
         entry.first = first_addr;
         entry.last  = range_end;
      end
      entry.size = {1'b0, entry.last} - {1'b0, entry.first} + SIZE_W'(1);
   end

endmodule

### hdl/ipv4tli_table.sv
// Entry table: first/last address memory, one write port and one
// registered read port. Depends on ipv4tli_pkg.
module ipv4tli_table #(
   parameter  int ENTRIES = 16,
   localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
   input  logic                           clock,
   input  logic                           wr_en,
   input  logic [IDX_W-1:0]               wr_idx,
   input  logic [ipv4tli_pkg::ADDR_W-1:0] wr_first,
   input  logic [ipv4tli_pkg::ADDR_W-1:0] wr_last,
   input  logic                           rd_en,
   input  logic [IDX_W-1:0]               rd_idx,
   output logic [ipv4tli_pkg::ADDR_W-1:0] rd_first,
   output logic [ipv4tli_pkg::ADDR_W-1:0] rd_last
);
   import ipv4tli_pkg::*;

   logic [ADDR_W-1:0] first_mem [ENTRIES];
   logic [ADDR_W-1:0] last_mem  [ENTRIES];
   logic [ADDR_W-1:0] rd_first_ff;
   logic [ADDR_W-1:0] rd_last_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         first_mem[wr_idx] <= wr_first;
         last_mem[wr_idx]  <= wr_last;
      end
      if (rd_en) begin
         rd_first_ff <= first_mem[rd_idx];
         rd_last_ff  <= last_mem[rd_idx];
      end
   end

   assign rd_first = rd_first_ff;
   assign rd_last  = rd_last_ff;

endmodule

### hdl/ipv4_target_list_iterator.sv
// IPv4 target list iterator top level; uses ipv4tli_pkg, ipv4tli_decode, ipv4tli_table.
// The response is registered: rsp_tvalid rises in the cycle after the request transfer.
// Throughput: 1 next per cycle inside an entry while the response side is not stalled;
//   clear, rewind, accepted append, walk start and each move to the next entry drop
//   req_tready while the registered table read port fetches the following entry.
// Reset: synchronous; clears counts and walk state (table left as is), then req_tready is low while entry 0 is fetched.
module ipv4_target_list_iterator #(
   parameter int ENTRIES = 16   // table depth, 1..256
) (
   input  logic         clock,
   input  logic         reset,
   // request channel
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [71:0]  req_tdata,   // first_addr[31:0], range_end[63:32],
                                     // prefix_len[69:64], zero[71:70]
   input  logic [2:0]   req_tuser,   // operation[1:0], entry_kind[2]
   // response channel
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [111:0] rsp_tdata,   // address[31:0], given_count[68:32],
                                     // total_count[105:69], zero[111:106]
   output logic [2:0]   rsp_tuser    // status[2:0]
);
   import ipv4tli_pkg::*;

   localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int ECW   = $clog2(ENTRIES + 1);   // holds 0..ENTRIES

   // request fields
   op_type            req_op;
   logic              req_kind;
   logic [ADDR_W-1:0] req_first;
   logic [ADDR_W-1:0] req_upper;
   logic [PLEN_W-1:0] req_plen;

   assign req_op    = op_type'(req_tuser[1:0]);
   assign req_kind  = req_tuser[2];
   assign req_first = req_tdata[31:0];
   assign req_upper = req_tdata[63:32];
   assign req_plen  = req_tdata[69:64];

   // walk and count state
   logic [ECW-1:0]    entry_count_ff,   entry_count_in;
   logic [ECW-1:0]    cur_entry_ff,     cur_entry_in;
   logic [SIZE_W-1:0] cur_addr_ff,      cur_addr_in;
   logic [ADDR_W-1:0] cur_last_ff,      cur_last_in;
   logic              started_ff,       started_in;
   logic [CNT_W-1:0]  given_ff,         given_in;
   logic [CNT_W-1:0]  total_ff,         total_in;
   logic              stale_ff,         stale_in;   // fetched entry out of date

   // result register
   logic              rsp_valid_ff,     rsp_valid_in;
   logic [ADDR_W-1:0] rsp_addr_ff,      rsp_addr_in;
   status_type        rsp_status_ff,    rsp_status_in;
   logic [CNT_W-1:0]  rsp_given_ff;
   logic [CNT_W-1:0]  rsp_total_ff;

   logic              req_xfer;
   entry_type         dec;
   logic              wr_en;
   logic [ECW-1:0]    fetch_idx;     // entry the read port must hold
   logic [ADDR_W-1:0] fetch_first;
   logic [ADDR_W-1:0] fetch_last;
   logic [CNT_W:0]    total_sum;

   ipv4tli_decode u_decode (
      .entry_kind (req_kind),
      .first_addr (req_first),
      .range_end  (req_upper),
      .prefix_len (req_plen),
      .entry      (dec)
   );

   // Read port always tracks the entry after the one being walked
   // (entry 0 before the walk starts).
   assign fetch_idx = started_ff ? ECW'(cur_entry_ff + ECW'(1)) : '0;

   ipv4tli_table #(.ENTRIES(ENTRIES)) u_table (
      .clock    (clock),
      .wr_en    (wr_en),
      .wr_idx   (entry_count_ff[IDX_W-1:0]),
      .wr_first (dec.first),
      .wr_last  (dec.last),
      .rd_en    (stale_ff),
      .rd_idx   (fetch_idx[IDX_W-1:0]),
      .rd_first (fetch_first),
      .rd_last  (fetch_last)
   );

   assign req_tready = !stale_ff && (!rsp_valid_ff || rsp_tready);
   assign req_xfer   = req_tvalid && req_tready;

   assign total_sum  = {1'b0, total_ff} + (CNT_W + 1)'(dec.size);

   always_comb begin
      entry_count_in = entry_count_ff;
      cur_entry_in   = cur_entry_ff;
      cur_addr_in    = cur_addr_ff;
      cur_last_in    = cur_last_ff;
      started_in     = started_ff;
      given_in       = given_ff;
      total_in       = total_ff;
      stale_in       = 1'b0;
      wr_en          = 1'b0;
      rsp_addr_in    = '0;
      rsp_status_in  = ST_DONE;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;

      if (req_xfer) begin
         rsp_valid_in = 1'b1;
         unique case (req_op)
            OP_CLEAR: begin
               entry_count_in = '0;
               total_in       = '0;
               cur_entry_in   = '0;
               cur_addr_in    = '0;
               started_in     = 1'b0;
               given_in       = '0;
               stale_in       = 1'b1;
            end
            OP_REWIND: begin
               cur_entry_in = '0;
               cur_addr_in  = '0;
               started_in   = 1'b0;
               given_in     = '0;
               stale_in     = 1'b1;
            end
            OP_APPEND: begin
               if (!dec.ok) begin
                  rsp_status_in = ST_REJECTED;
               end else if (entry_count_ff >= ECW'(ENTRIES)) begin
                  rsp_status_in = ST_FULL;
               end else begin
                  rsp_status_in  = ST_ACCEPTED;
                  wr_en          = 1'b1;
                  entry_count_in = ECW'(entry_count_ff + ECW'(1));
                  total_in       = total_sum[CNT_W] ? CNT_MAX : total_sum[CNT_W-1:0];
                  stale_in       = 1'b1;   // new entry may be the fetched one
               end
            end
            OP_NEXT: begin
               rsp_status_in = ST_GIVEN;
               if (!started_ff) begin
                  if (entry_count_ff == '0) begin
                     rsp_status_in = ST_FINISHED;
                  end else begin
                     // start on entry 0, already held by the read port
                     started_in   = 1'b1;
                     cur_entry_in = '0;
                     cur_last_in  = fetch_last;
                     rsp_addr_in  = fetch_first;
                     cur_addr_in  = {1'b0, fetch_first} + SIZE_W'(1);
                     stale_in     = 1'b1;
                  end
               end else if (cur_addr_ff > {1'b0, cur_last_ff}) begin
                  if (fetch_idx >= entry_count_ff) begin
                     rsp_status_in = ST_FINISHED;
                  end else begin
                     cur_entry_in = fetch_idx;
                     cur_last_in  = fetch_last;
                     rsp_addr_in  = fetch_first;
                     cur_addr_in  = {1'b0, fetch_first} + SIZE_W'(1);
                     stale_in     = 1'b1;
                  end
               end else begin
                  rsp_addr_in = cur_addr_ff[ADDR_W-1:0];
                  cur_addr_in = cur_addr_ff + SIZE_W'(1);
               end
               if (rsp_status_in == ST_GIVEN && given_ff != CNT_MAX) begin
                  given_in = given_ff + CNT_W'(1);
               end
            end
            default: begin
               rsp_status_in = ST_DONE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_count_ff <= '0;
         cur_entry_ff   <= '0;
         cur_addr_ff    <= '0;
         started_ff     <= 1'b0;
         given_ff       <= '0;
         total_ff       <= '0;
         stale_ff       <= 1'b1;
         rsp_valid_ff   <= 1'b0;
      end else begin
         entry_count_ff <= entry_count_in;
         cur_entry_ff   <= cur_entry_in;
         cur_addr_ff    <= cur_addr_in;
         started_ff     <= started_in;
         given_ff       <= given_in;
         total_ff       <= total_in;
         stale_ff       <= stale_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // payload registers: no reset
   always_ff @(posedge clock) begin
      cur_last_ff <= cur_last_in;
      if (req_xfer) begin
         rsp_addr_ff   <= rsp_addr_in;
         rsp_status_ff <= rsp_status_in;
         rsp_given_ff  <= given_in;
         rsp_total_ff  <= total_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b0, rsp_total_ff, rsp_given_ff, rsp_addr_ff};
   assign rsp_tuser  = rsp_status_ff;

endmodule

### hdl/ipv4tli_checker.sv
// Port-level checker for the IPv4 target list iterator, with its bind.
// Depends on ipv4tli_pkg and ipv4_target_list_iterator.
module ipv4tli_checker (
   input logic         clock,
   input logic         reset,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [111:0] rsp_tdata,
   input logic [2:0]   rsp_tuser
);
   import ipv4tli_pkg::*;

   // a stalled response holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("response changed while stalled");

   // address is zero unless one was given
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != ST_GIVEN |-> rsp_tdata[31:0] == 32'd0)
      else $error("nonzero address without ST_GIVEN");

   // never more addresses handed out than loaded
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[68:32] <= rsp_tdata[105:69])
      else $error("given count exceeds total count");

   // clear and rewind leave the given count at zero
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == ST_DONE |-> rsp_tdata[68:32] == 37'd0)
      else $error("given count nonzero after clear or rewind");

   // status codes stay in range
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tuser <= ST_DONE)
      else $error("status code out of range");

endmodule

bind ipv4_target_list_iterator ipv4tli_checker u_ipv4tli_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

### verif/tb_ipv4_target_list_iterator.sv
// Self-checking testbench for ipv4_target_list_iterator: directed table, then random
// load/walk sequences, each response checked against its typed value or an in-bench model of the walk.
// Depends on ipv4tli_pkg and the DUT sources only.
`timescale 1ns / 1ps

module tb_ipv4_target_list_iterator;
   import ipv4tli_pkg::*;

   localparam int  TBL_DEPTH     = 16;
   localparam int  DIR_ROWS      = 25;
   localparam int  RANDOM_ITEMS  = 2000;
   localparam int  QUIET_ITEMS   = 300;       // tail of the run with no idling at all
   localparam int  SETTLE_CYCLES = 8;
   localparam int  RUN_LIMIT_NS  = 1_000_000; // many times the slowest run
   localparam int  GIVEN_LSB     = ADDR_W;
   localparam int  TOTAL_LSB     = ADDR_W + CNT_W;
   localparam bit  BY_MODEL      = 1'b0;      // row checked against the model
   localparam bit  TYPED         = 1'b1;      // row carries its own response

   // One request, fields as the block sees them.
   typedef struct packed {
      op_type            op;
      logic              kind;         // 0 network/prefix, 1 inclusive range
      logic [ADDR_W-1:0] first_addr;
      logic [ADDR_W-1:0] range_end;
      logic [PLEN_W-1:0] prefix_len;
   } target_req_type;

   // One response.
   typedef struct packed {
      logic [ADDR_W-1:0] address;
      status_type        status;
      logic [CNT_W-1:0]  given;
      logic [CNT_W-1:0]  total;
   } target_rsp_type;

   typedef struct packed {
      target_req_type req;
      logic           typed;
      target_rsp_type rsp;
   } dir_row_type;

   logic         clock = 1'b0;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [71:0]  req_tdata;    // first_addr, range_end, prefix_len, zero pad
   logic [2:0]   req_tuser;    // operation, entry_kind
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [111:0] rsp_tdata;    // address, given_count, total_count, zero pad
   logic [2:0]   rsp_tuser;    // status

   ipv4_target_list_iterator #(.ENTRIES(TBL_DEPTH)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #2 clock = ~clock;

   // ---------------------------------------------------------------------------
   // Model of the target table and the walk. State starts at its reset values;
   // reset is applied once, so no separate reset of the model is needed.
   // ---------------------------------------------------------------------------
   logic [ADDR_W-1:0] tbl_first [TBL_DEPTH];
   logic [ADDR_W-1:0] tbl_last  [TBL_DEPTH];
   int                n_entries    = 0;
   int                walk_entry   = 0;
   logic [ADDR_W:0]   walk_addr    = '0;   // one bit wider: no wrap past the top
   logic              walk_started = 1'b0;
   logic [CNT_W-1:0]  given_cnt    = '0;
   logic [CNT_W-1:0]  total_cnt    = '0;

   target_rsp_type step_outcomes [$];   // responses still owed by the DUT, oldest first
   int             mismatch_count = 0;
   int             items_sent     = 0;
   bit             idle_en        = 1'b1;
   bit             stall_en       = 1'b1;

   function automatic logic [CNT_W-1:0] sat_add(logic [CNT_W-1:0] a, logic [CNT_W-1:0] b);
      logic [CNT_W:0] s;
      s = a + b;
      return s[CNT_W] ? CNT_MAX : s[CNT_W-1:0];
   endfunction

   // Applies one request to the model and returns the response it must produce.
   function automatic target_rsp_type target_list_step(target_req_type r);
      target_rsp_type    res;
      logic [ADDR_W-1:0] host;
      logic [ADDR_W-1:0] lo_a;
      logic [ADDR_W-1:0] hi_a;
      logic              valid;
      res        = '0;
      res.status = ST_DONE;
      case (r.op)
         OP_CLEAR, OP_REWIND: begin
            if (r.op == OP_CLEAR) begin
               n_entries = 0;
               total_cnt = '0;
            end
            walk_entry   = 0;
            walk_addr    = '0;
            walk_started = 1'b0;
            given_cnt    = '0;
         end
         OP_APPEND: begin
            // network entry: host part cleared for first, set for last
            host  = {ADDR_W{1'b1}} >> r.prefix_len;
            lo_a  = r.kind ? r.first_addr : (r.first_addr & ~host);
            hi_a  = r.kind ? r.range_end : (r.first_addr | host);
            valid = r.kind ? (r.range_end >= r.first_addr) : (r.prefix_len <= 6'd32);
            // validity wins over a full table
            if (!valid) begin
               res.status = ST_REJECTED;
            end else if (n_entries >= TBL_DEPTH) begin
               res.status = ST_FULL;
            end else begin
               tbl_first[n_entries] = lo_a;
               tbl_last[n_entries]  = hi_a;
               n_entries++;
               total_cnt  = sat_add(total_cnt,
                  {{(CNT_W-ADDR_W){1'b0}}, hi_a} - {{(CNT_W-ADDR_W){1'b0}}, lo_a} + 1'b1);
               res.status = ST_ACCEPTED;
            end
         end
         default: begin   // next address
            res.status = ST_FINISHED;
            if (!walk_started && n_entries != 0) begin
               walk_entry   = 0;
               walk_addr    = {1'b0, tbl_first[0]};
               walk_started = 1'b1;
            end
            if (walk_started && walk_entry < n_entries) begin
               // current entry used up: step on only if another entry is loaded
               if (walk_addr > {1'b0, tbl_last[walk_entry]} && walk_entry + 1 < n_entries) begin
                  walk_entry++;
                  walk_addr = {1'b0, tbl_first[walk_entry]};
               end
               if (walk_addr <= {1'b0, tbl_last[walk_entry]}) begin
                  res.address = walk_addr[ADDR_W-1:0];
                  walk_addr++;
                  given_cnt   = sat_add(given_cnt, CNT_W'(1));
                  res.status  = ST_GIVEN;
               end
            end
         end
      endcase
      res.given = given_cnt;
      res.total = total_cnt;
      return res;
   endfunction

   // ---------------------------------------------------------------------------
   // Stimulus builders
   // ---------------------------------------------------------------------------
   function automatic dir_row_type step_row(op_type op, logic kind, logic [ADDR_W-1:0] a,
                                            logic [ADDR_W-1:0] b, logic [PLEN_W-1:0] p);
      dir_row_type d;
      d       = '0;
      d.req   = '{op, kind, a, b, p};
      d.typed = BY_MODEL;
      return d;
   endfunction

   function automatic dir_row_type known_row(op_type op, logic kind, logic [ADDR_W-1:0] a,
                                             logic [ADDR_W-1:0] b, logic [PLEN_W-1:0] p,
                                             logic [ADDR_W-1:0] ea, status_type es,
                                             logic [CNT_W-1:0] eg, logic [CNT_W-1:0] et);
      dir_row_type d;
      d       = step_row(op, kind, a, b, p);
      d.typed = TYPED;
      d.rsp   = '{ea, es, eg, et};
      return d;
   endfunction

   // Every field random over its full range.
   function automatic target_req_type rand_fields();
      target_req_type r;
      r.op         = op_type'($urandom_range(0, 3));
      r.kind       = 1'($urandom_range(0, 1));
      r.first_addr = $urandom;
      r.range_end  = $urandom;
      r.prefix_len = 6'($urandom_range(0, 63));
      return r;
   endfunction

   // Append; well-formed ones are small entries so walks actually finish.
   function automatic target_req_type rand_append(bit well_formed);
      target_req_type r;
      r    = rand_fields();
      r.op = OP_APPEND;
      if (!well_formed) return r;
      if (r.kind == 1'b0) begin
         r.prefix_len = 6'($urandom_range(26, 32));
         if ($urandom_range(0, 7) == 0) r.first_addr[31:8] = '1;   // near the top
      end else begin
         if ($urandom_range(0, 3) == 0) r.first_addr = 32'hFFFF_FFFF - $urandom_range(0, 6);
         r.range_end = (r.first_addr > 32'hFFFF_FFF6) ? 32'hFFFF_FFFF
                                                       : r.first_addr + $urandom_range(0, 9);
      end
      return r;
   endfunction

   // ---------------------------------------------------------------------------
   // Request side. Called at a falling edge; returns at the falling edge after
   // the transfer, so req_tvalid stays high back to back when no gap is drawn.
   // ---------------------------------------------------------------------------
   task automatic send_step(input target_req_type r, input bit typed,
                            input target_rsp_type known);
      target_rsp_type model;
      if (idle_en && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {2'b00, r.prefix_len, r.range_end, r.first_addr};
      req_tuser  <= {r.kind, r.op};
      do @(posedge clock); while (!req_tready);
      // transfer at this edge: the model moves in step with the DUT
      model = target_list_step(r);
      step_outcomes.push_back(typed ? known : model);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic send_op(input op_type op);
      target_req_type r;
      r    = rand_fields();   // fields the operation ignores stay random
      r.op = op;
      send_step(r, BY_MODEL, '0);
   endtask

   // Hold the request side until every owed response has come back.
   task automatic drain_outcomes();
      req_tvalid <= 1'b0;
      while (step_outcomes.size() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   // ---------------------------------------------------------------------------
   // Response side: random stall bursts, driven at the falling edge.
   // ---------------------------------------------------------------------------
   initial begin
      rsp_tready = 1'b0;
      @(negedge clock);
      forever begin
         if (stall_en && $urandom_range(0, 4) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         @(negedge clock);
      end
   end

   // Every response transfer is matched against the oldest owed response.
   always @(posedge clock) begin : check_rsp
      target_rsp_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (step_outcomes.size() == 0) begin
            $error("response transfer with nothing owed: tdata %h status %0d",
                   rsp_tdata, rsp_tuser);
            mismatch_count++;
         end else begin
            want = step_outcomes.pop_front();
            if (rsp_tdata[ADDR_W-1:0] !== want.address) begin
               $error("address: expected %h, actual %h", want.address, rsp_tdata[ADDR_W-1:0]);
               mismatch_count++;
            end
            if (rsp_tuser !== want.status) begin
               $error("status: expected %0d, actual %0d", want.status, rsp_tuser);
               mismatch_count++;
            end
            if (rsp_tdata[GIVEN_LSB +: CNT_W] !== want.given) begin
               $error("given_count: expected %0d, actual %0d",
                      want.given, rsp_tdata[GIVEN_LSB +: CNT_W]);
               mismatch_count++;
            end
            if (rsp_tdata[TOTAL_LSB +: CNT_W] !== want.total) begin
               $error("total_count: expected %0d, actual %0d",
                      want.total, rsp_tdata[TOTAL_LSB +: CNT_W]);
               mismatch_count++;
            end
         end
      end
   end

   // Hard stop if the run hangs.
   initial begin
      #(RUN_LIMIT_NS);
      $display("FAIL");
      $finish;
   end

   // ---------------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------------
   initial begin : main_seq
      dir_row_type dir_rows [DIR_ROWS];
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = '0;

      // Directed rows. Typed responses are the obvious ones; the rest go to the model.
      dir_rows = '{
         // empty table right after reset, then a rewind of nothing
         known_row(OP_NEXT,   1'b0, 32'h0, 32'h0, 6'd0, 32'h0, ST_FINISHED, 37'd0, 37'd0),
         known_row(OP_REWIND, 1'b0, 32'h0, 32'h0, 6'd0, 32'h0, ST_DONE, 37'd0, 37'd0),
         // rejects: prefix just over 32, largest prefix code, backward range
         known_row(OP_APPEND, 1'b0, 32'hFFFF_FFFF, 32'h0, 6'd33,
                   32'h0, ST_REJECTED, 37'd0, 37'd0),
         known_row(OP_APPEND, 1'b0, 32'h0, 32'hFFFF_FFFF, 6'd63,
                   32'h0, ST_REJECTED, 37'd0, 37'd0),
         known_row(OP_APPEND, 1'b1, 32'h0000_000A, 32'h0000_0009, 6'd0,
                   32'h0, ST_REJECTED, 37'd0, 37'd0),
         // /30 network, host bits in the given address are dropped
         known_row(OP_APPEND, 1'b0, 32'hC0A8_014D, 32'hFFFF_FFFF, 6'd30,
                   32'h0, ST_ACCEPTED, 37'd0, 37'd4),
         known_row(OP_NEXT,   1'b0, 32'h0, 32'h0, 6'd0, 32'hC0A8_014C, ST_GIVEN, 37'd1, 37'd4),
         // range at the very top, appended while the walk is running
         known_row(OP_APPEND, 1'b1, 32'hFFFF_FFFE, 32'hFFFF_FFFF, 6'd63,
                   32'h0, ST_ACCEPTED, 37'd1, 37'd6),
         step_row(OP_NEXT, 1'b0, 32'h0, 32'h0, 6'd0),
         step_row(OP_NEXT, 1'b0, 32'h0, 32'h0, 6'd0),
         step_row(OP_NEXT, 1'b0, 32'h0, 32'h0, 6'd0),
         step_row(OP_NEXT, 1'b0, 32'h0, 32'h0, 6'd0),
         step_row(OP_NEXT, 1'b0, 32'h0, 32'h0, 6'd0),
         // walk stops after 255.255.255.255 instead of wrapping
         known_row(OP_NEXT,   1'b0, 32'h0, 32'h0, 6'd0, 32'h0, ST_FINISHED, 37'd6, 37'd6),
         // single-address /32 at zero, picked up by the finished walk
         known_row(OP_APPEND, 1'b0, 32'h0, 32'h0, 6'd32, 32'h0, ST_ACCEPTED, 37'd6, 37'd7),
         step_row(OP_NEXT, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'd63),
         known_row(OP_REWIND, 1'b1, 32'hFFFF_FFFF, 32'h0, 6'd63,
                   32'h0, ST_DONE, 37'd0, 37'd7),
         // whole address space twice: /0 network and full range
         known_row(OP_APPEND, 1'b0, 32'h1234_5678, 32'hFFFF_FFFF, 6'd0,
                   32'h0, ST_ACCEPTED, 37'd0, 37'h1_0000_0007),
         known_row(OP_APPEND, 1'b1, 32'h0, 32'hFFFF_FFFF, 6'd0,
                   32'h0, ST_ACCEPTED, 37'd0, 37'h2_0000_0007),
         // one-address range; prefix field ignored
         known_row(OP_APPEND, 1'b1, 32'h0000_0005, 32'h0000_0005, 6'd63,
                   32'h0, ST_ACCEPTED, 37'd0, 37'h2_0000_0008),
         step_row(OP_NEXT, 1'b0, 32'h0, 32'h0, 6'd0),
         step_row(OP_APPEND, 1'b0, 32'hFFFF_FFFF, 32'h0, 6'd32),
         known_row(OP_CLEAR, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'd63,
                   32'h0, ST_DONE, 37'd0, 37'd0),
         known_row(OP_NEXT,  1'b0, 32'h0, 32'h0, 6'd0, 32'h0, ST_FINISHED, 37'd0, 37'd0),
         step_row(OP_APPEND, 1'b0, 32'h0A00_0001, 32'h5555_AAAA, 6'd31)
      };

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (dir_rows[i]) send_step(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].rsp);
      drain_outcomes();   // sender holds off until the DUT has caught up

      // Random part: load-then-walk sequences half the time, plus fills, long walks and raw noise.
      while (items_sent < DIR_ROWS + RANDOM_ITEMS) begin
         if (items_sent >= DIR_ROWS + RANDOM_ITEMS - QUIET_ITEMS) begin
            idle_en  = 1'b0;
            stall_en = 1'b0;
         end else begin
            idle_en  = ($urandom_range(0, 3) != 0);
            stall_en = ($urandom_range(0, 3) != 0);
         end
         if (idle_en && $urandom_range(0, 11) == 0) drain_outcomes();
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: begin
               if ($urandom_range(0, 1) == 1) send_op(OP_CLEAR);
               repeat ($urandom_range(1, 5))
                  send_step(rand_append($urandom_range(0, 7) != 0), BY_MODEL, '0);
               if ($urandom_range(0, 2) == 0) send_op(OP_REWIND);
               repeat ($urandom_range(1, 40)) send_op(OP_NEXT);
            end
            5: begin
               // overfill: later valid appends see a full table, broken ones still reject
               send_op(OP_CLEAR);
               repeat (22) send_step(rand_append($urandom_range(0, 4) != 0), BY_MODEL, '0);
               repeat ($urandom_range(1, 30)) send_op(OP_NEXT);
            end
            6: repeat ($urandom_range(40, 120)) send_op(OP_NEXT);
            default: repeat ($urandom_range(1, 8)) send_step(rand_fields(), BY_MODEL, '0);
         endcase
      end

      drain_outcomes();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0) $display("PASS");
      else $display("FAIL");
      $finish;
   end

endmodule

### filelist.f
hdl/ipv4tli_pkg.sv
hdl/ipv4tli_decode.sv
hdl/ipv4tli_table.sv
hdl/ipv4_target_list_iterator.sv
hdl/ipv4tli_checker.sv
verif/tb_ipv4_target_list_iterator.sv
